>>> rtl/duplicate_key_set_assoc_table_top_assert.svh
// Assertion macros shared by the checker. Each expects clk and rst in scope.
`ifndef DUPLICATE_KEY_SET_ASSOC_TABLE_TOP_ASSERT_SVH
`define DUPLICATE_KEY_SET_ASSOC_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define DKST_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dkst assertion failed");

// Next-cycle implication.
`define DKST_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dkst assertion failed");

`endif

>>> rtl/dkst_pkg.sv
`default_nettype none
package dkst_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int SETS          = 16;
  localparam int KEY_BYTES     = 32;

  localparam int WAYS  = (TABLE_ENTRIES + SETS - 1) / SETS;
  localparam int KEY_W = KEY_BYTES * 8;
  localparam int CNT_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int SUM_W = $clog2(KEY_BYTES * 255 + 1);
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W = $clog2(TABLE_ENTRIES);
  localparam int EXT_W = $clog2(3 * TABLE_ENTRIES);

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_EXISTS = 1'b1;

  localparam logic [1:0] STATUS_INSERT_DONE = 2'd0;
  localparam logic [1:0] STATUS_HIT         = 2'd1;
  localparam logic [1:0] STATUS_MISS        = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [SET_W-1:0] set_idx;
    logic [KEY_W-1:0] key;
  } dkst_job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_LOOK,
    ST_CMP
  } dkst_state_t;

  // Table entry of a given way in a set; may run past the table for a way beyond the set.
  function automatic logic [EXT_W-1:0] entry_of(logic [SET_W-1:0] s, logic [WAY_W:0] w);
    return EXT_W'(s) + EXT_W'(w) * EXT_W'(SETS);
  endfunction

endpackage
`default_nettype wire

>>> rtl/dkst_front.sv
`default_nettype none
module dkst_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               command,
  input  wire logic [7:0]         key_byte,
  input  wire logic               q_full,
  output logic                    push,
  output dkst_pkg::dkst_job_t     push_job
);
  import dkst_pkg::*;

  logic [7:0]       key_buf [KEY_BYTES];
  logic [CNT_W-1:0] byte_cnt;
  logic [CNT_W-1:0] byte_cnt_next;
  logic [SUM_W-1:0] byte_sum;
  logic [SUM_W-1:0] sum_next;
  logic             last;
  logic             accept;

  assign last     = (byte_cnt == CNT_W'(KEY_BYTES - 1));
  assign in_ready = !last || !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && last;
  assign sum_next = byte_sum + SUM_W'(key_byte);

  always_comb begin
    byte_cnt_next = last ? '0 : byte_cnt + CNT_W'(1);
  end

  // The final byte goes straight into the job; it never needs to land in the buffer.
  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      push_job.key[i*8 +: 8] = (CNT_W'(i) == byte_cnt) ? key_byte : key_buf[i];
    end
    push_job.cmd     = command;
    push_job.set_idx = SET_W'((32'(sum_next) % TABLE_ENTRIES) % SETS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt <= '0;
      byte_sum <= '0;
    end else if (accept) begin
      byte_cnt <= byte_cnt_next;
      byte_sum <= last ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_buf[byte_cnt] <= key_byte;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dkst_queue.sv
`default_nettype none
module dkst_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  dkst_pkg::dkst_job_t     push_job,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output dkst_pkg::dkst_job_t     head_job
);
  import dkst_pkg::*;

  dkst_job_t         slots [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dkst_back.sv
`default_nettype none
module dkst_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  dkst_pkg::dkst_job_t     head_job,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status
);
  import dkst_pkg::*;

  logic [KEY_W-1:0]   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [WAY_W-1:0]   next_way [SETS];

  dkst_state_t        state;
  dkst_state_t        state_next;
  dkst_job_t          job;
  logic [WAY_W:0]     look_way;
  logic [KEY_W-1:0]   rd_data;
  logic               rd_ok;

  logic               take;
  logic               mem_we;
  logic               rd_en;
  logic               res_load;
  logic [1:0]         res_code;
  logic               cmp_eq;
  logic               cmp_last;
  logic [EXT_W-1:0]   vict_try;
  logic [WAY_W:0]     vict_way;
  logic [ENT_W-1:0]   vict_entry;
  logic [WAY_W:0]     way_inc;
  logic [WAY_W-1:0]   way_after;
  logic [EXT_W-1:0]   look_ext;
  logic [ENT_W-1:0]   rd_addr;

  // Victim way, falling back to way 0 if the pointer lies past this set's last entry.
  always_comb begin
    vict_try = entry_of(job.set_idx, {1'b0, next_way[job.set_idx]});
    if (vict_try >= EXT_W'(TABLE_ENTRIES)) begin
      vict_way   = '0;
      vict_entry = ENT_W'(job.set_idx);
    end else begin
      vict_way   = {1'b0, next_way[job.set_idx]};
      vict_entry = vict_try[ENT_W-1:0];
    end
    way_inc = vict_way + (WAY_W+1)'(1);
    if (entry_of(job.set_idx, way_inc) >= EXT_W'(TABLE_ENTRIES)) begin
      way_after = '0;
    end else begin
      way_after = way_inc[WAY_W-1:0];
    end
  end

  assign look_ext = entry_of(job.set_idx, look_way);
  assign rd_addr  = look_ext[ENT_W-1:0];
  assign cmp_eq   = ((rd_ok ? rd_data : '0) == job.key);
  assign cmp_last = (entry_of(job.set_idx, look_way + (WAY_W+1)'(1)) >= EXT_W'(TABLE_ENTRIES));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head_valid && !out_valid) begin
          state_next = (head_job.cmd == CMD_INSERT) ? ST_INSERT : ST_LOOK;
        end
      end
      ST_INSERT: state_next = ST_IDLE;
      ST_LOOK:   state_next = ST_CMP;
      ST_CMP: begin
        state_next = (cmp_eq || cmp_last) ? ST_IDLE : ST_LOOK;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    take     = 1'b0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    res_load = 1'b0;
    res_code = STATUS_INSERT_DONE;
    unique case (state)
      ST_IDLE:   take = head_valid && !out_valid;
      ST_INSERT: begin
        mem_we   = 1'b1;
        res_load = 1'b1;
        res_code = STATUS_INSERT_DONE;
      end
      ST_LOOK:   rd_en = 1'b1;
      ST_CMP: begin
        res_load = cmp_eq || cmp_last;
        res_code = cmp_eq ? STATUS_HIT : STATUS_MISS;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  assign pop = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      entry_valid <= '0;
      for (int s = 0; s < SETS; s++) begin
        next_way[s] <= '0;
      end
    end else begin
      state <= state_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        entry_valid[vict_entry] <= 1'b1;
        next_way[job.set_idx]   <= way_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job      <= head_job;
      look_way <= '0;
    end else if (state == ST_CMP) begin
      look_way <= look_way + (WAY_W+1)'(1);
    end
    if (res_load) begin
      status <= res_code;
    end
  end

  // Entries never written read as the all-zero key through their valid bit.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[vict_entry] <= job.key;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_ok   <= entry_valid[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/duplicate_key_set_assoc_table_top.sv
// Channel  Direction  Handshake              Fields
// in       sink       in_valid / in_ready    command (1), key_byte (8)
// out      source     out_valid / out_ready  status (2)
//
// Key bytes are taken at one per cycle; in_ready drops only on a final byte while the
// two-deep job queue is full. An insert passes the back end's INSERT state, an exists a
// LOOK and a CMP state per way compared, as the key memory has a single read port; the
// back end keeps pace with the 32 bytes of the next key. Reset clears the entry valid
// bits and the way pointers at once; no clearing pass is needed. A stalled result holds
// the back end, which then fills the queue and finally stalls the input.
`default_nettype none
module duplicate_key_set_assoc_table_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       command,
  input  wire logic [7:0] key_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status
);
  import dkst_pkg::*;

  dkst_job_t push_job;
  dkst_job_t head_job;
  logic      push;
  logic      q_full;
  logic      head_valid;
  logic      pop;

  dkst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .key_byte (key_byte),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  dkst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  dkst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status)
  );

endmodule
`default_nettype wire

>>> rtl/dkst_checker.sv
`default_nettype none
`include "duplicate_key_set_assoc_table_top_assert.svh"
module dkst_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       command,
  input wire logic [7:0] key_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] status
);
  import dkst_pkg::*;

  logic [CNT_W-1:0] pos;
  logic [2:0]       pending;
  logic             final_beat;
  logic             out_beat;
  logic             in_seen;

  assign final_beat = in_valid && in_ready && (pos == CNT_W'(KEY_BYTES - 1));
  assign out_beat   = out_valid && out_ready;
  assign in_seen    = in_valid;

  // Keys whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      pending <= '0;
    end else begin
      if (in_seen && in_ready) begin
        pos <= (pos == CNT_W'(KEY_BYTES - 1)) ? '0 : pos + CNT_W'(1);
      end
      if (final_beat && !out_beat) begin
        pending <= pending + 3'd1;
      end else if (out_beat && !final_beat) begin
        pending <= pending - 3'd1;
      end
    end
  end

  `DKST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
  `DKST_ASSERT_IMPL(a_no_spurious, out_valid, pending != 3'd0)
  `DKST_ASSERT_IMPL(a_bounded, 1'b1, pending <= 3'd4)
  `DKST_ASSERT_IMPL(a_stall_final, !in_ready, pos == CNT_W'(KEY_BYTES - 1))

endmodule

bind duplicate_key_set_assoc_table_top dkst_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .command   (command),
  .key_byte  (key_byte),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status)
);
`default_nettype wire
